/* rtl/core/qre_pkg.sv */
`default_nettype none

package qre_pkg;

  localparam int CMD_W       = 2;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int CPR_W       = 16;
  localparam int ALPHA_W     = 9;
  localparam int TIME_W      = 32;
  localparam int SPEED_W     = 16;
  localparam int RAW_W       = 32;
  localparam int QUO_W       = 31;
  localparam int US_W        = 26;
  localparam int ALPHA_SHIFT = 8;

  localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_COUNTS_PER_REV = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA_Q8       = 1'b1;

  localparam logic [CPR_W-1:0]   CPR_RESET   = 16'd480;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd26;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [US_W-1:0]    US_PER_MIN  = 26'd60000000;

  localparam logic signed [RAW_W-1:0] SPEED_MAX = 32'sd32767;
  localparam logic signed [RAW_W-1:0] SPEED_MIN = -32'sd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN,
    ST_NUM,
    ST_CHK,
    ST_DIV,
    ST_SIGN,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/quadrature_rpm_estimator_core.sv */
// Encoder speed estimator. Each input item is an encoder edge (cmd 0), a
// microsecond tick (cmd 1) or a sample request (cmd 2); code 3 is ignored.
// Edges and ticks give no result. A sample request gives one result item,
// the exponentially averaged speed in whole rpm. Three set-up states (DEN,
// NUM, CHK) form the divisor and the numerator, the restoring divider
// then produces one of the 31 quotient bits per cycle, and four more
// states (SIGN, MIX1 to MIX3) apply the sign and run the average update.
// A quotient that saturates skips the divider, and zero elapsed time or
// zero counts per revolution skips the arithmetic. A result waits in the
// output state while the output register still holds a stalled one.
// The block takes no input item while a sample is in work, but it
// accepts items while a finished result still waits in the output register.

`default_nettype none

module quadrature_rpm_estimator_core #(
  parameter int FRACTION_BITS = 8,
  parameter int COUNT_BITS    = 32
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [qre_pkg::CFG_ADDR_W-1:0]          cfg_addr_i,
  input  wire logic [qre_pkg::CFG_DATA_W-1:0]          cfg_wdata_i,
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic [qre_pkg::CMD_W-1:0]               cmd_i,
  input  wire logic                                    encoder_dir_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic signed [qre_pkg::SPEED_W-1:0]           speed_rpm_o
);

  import qre_pkg::*;

  localparam int DEN_W = CPR_W + TIME_W;
  localparam int NUM_W = COUNT_BITS + US_W;
  localparam int N_W   = NUM_W + FRACTION_BITS;
  localparam int HI_W  = N_W - QUO_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam int PRD_W = RAW_W + ALPHA_W + 1;

  state_e state_q, state_d;

  logic [CPR_W-1:0]          cpr_q;
  logic [ALPHA_W-1:0]        alpha_q;
  logic [COUNT_BITS-1:0]     position_q;
  logic [COUNT_BITS-1:0]     sampled_q;
  logic [TIME_W-1:0]         elapsed_q;
  logic signed [RAW_W-1:0]   filt_q, filt_d;
  logic                      out_valid_q;
  logic signed [SPEED_W-1:0] speed_q, speed_d;

  logic [COUNT_BITS-1:0]     delta_q;
  logic [TIME_W-1:0]         el_q;
  logic [DEN_W-1:0]          den_q;
  logic                      neg_q;
  logic [COUNT_BITS-1:0]     mag_q;
  logic [NUM_W-1:0]          num_q;
  logic [DEN_W-1:0]          rem_q;
  logic [QUO_W-1:0]          low_q;
  logic [QUO_W-1:0]          quo_q;
  logic [CNT_W-1:0]          cnt_q;
  logic signed [RAW_W-1:0]   raw_q;
  logic signed [PRD_W-1:0]   prod_q;
  logic signed [PRD_W-1:0]   sum_q;

  logic                      in_accept;
  logic                      out_load;
  logic [N_W-1:0]            n_full;
  logic [CMP_W-1:0]          hi_ext;
  logic [CMP_W-1:0]          den_ext;
  logic                      quo_sat;
  logic [DEN_W:0]            trial;
  logic                      trial_ge;
  logic [ALPHA_W-1:0]        w_new;
  logic [ALPHA_W-1:0]        w_old;
  logic signed [PRD_W-1:0]   sum_adj;
  logic signed [RAW_W-1:0]   filt_adj;
  logic signed [RAW_W-1:0]   whole;

  assign in_accept = in_valid_i && !in_stall_o;

  assign n_full   = {num_q, {FRACTION_BITS{1'b0}}};
  assign hi_ext   = CMP_W'(n_full[N_W-1:QUO_W]);
  assign den_ext  = CMP_W'(den_q);
  assign quo_sat  = hi_ext >= den_ext;
  assign trial    = {rem_q, low_q[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, den_q};

  assign w_new = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign w_old = ALPHA_ONE - w_new;

  assign sum_adj  = sum_q + (sum_q[PRD_W-1] ? PRD_W'(ALPHA_ONE - 1'b1) : '0);
  assign filt_adj = filt_q + (filt_q[RAW_W-1] ? RAW_W'((2 ** FRACTION_BITS) - 1) : '0);
  assign whole    = filt_adj >>> FRACTION_BITS;

  always_comb begin
    if (whole > SPEED_MAX) begin
      speed_d = SPEED_MAX[SPEED_W-1:0];
    end else if (whole < SPEED_MIN) begin
      speed_d = SPEED_MIN[SPEED_W-1:0];
    end else begin
      speed_d = whole[SPEED_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && cmd_i == CMD_SAMPLE) begin
          state_d = ST_DEN;
        end
      end
      ST_DEN:  state_d = ST_NUM;
      ST_NUM:  state_d = ST_CHK;
      ST_CHK: begin
        if (den_q == '0) begin
          state_d = ST_OUT;
        end else if (quo_sat) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: state_d = ST_MIX1;
      ST_MIX1: state_d = ST_MIX2;
      ST_MIX2: state_d = ST_MIX3;
      ST_MIX3: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != ST_IDLE;
    out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  end

  assign filt_d = RAW_W'(sum_adj >>> ALPHA_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cpr_q       <= CPR_RESET;
      alpha_q     <= ALPHA_RESET;
      position_q  <= '0;
      sampled_q   <= '0;
      elapsed_q   <= '0;
      filt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_COUNTS_PER_REV: cpr_q   <= cfg_wdata_i[CPR_W-1:0];
          CFG_ALPHA_Q8:       alpha_q <= cfg_wdata_i[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        case (cmd_i)
          CMD_EDGE: begin
            if (encoder_dir_i) begin
              position_q <= position_q + 1'b1;
            end else begin
              position_q <= position_q - 1'b1;
            end
          end
          CMD_TICK: begin
            if (elapsed_q != '1) begin
              elapsed_q <= elapsed_q + 1'b1;
            end
          end
          CMD_SAMPLE: begin
            sampled_q <= position_q;
            elapsed_q <= '0;
          end
          default: ;
        endcase
      end
      if (state_q == ST_MIX3) begin
        filt_q <= filt_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      speed_q <= speed_d;
    end
    case (state_q)
      ST_IDLE: begin
        delta_q <= position_q - sampled_q;
        el_q    <= elapsed_q;
      end
      ST_DEN: begin
        den_q <= DEN_W'(cpr_q) * DEN_W'(el_q);
        neg_q <= delta_q[COUNT_BITS-1];
        mag_q <= delta_q[COUNT_BITS-1] ? (~delta_q + 1'b1) : delta_q;
      end
      ST_NUM: begin
        num_q <= NUM_W'(mag_q) * NUM_W'(US_PER_MIN);
      end
      ST_CHK: begin
        rem_q <= DEN_W'(hi_ext);
        low_q <= n_full[QUO_W-1:0];
        quo_q <= '1;
        cnt_q <= CNT_W'(QUO_W);
      end
      ST_DIV: begin
        rem_q <= trial_ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        low_q <= {low_q[QUO_W-2:0], 1'b0};
        quo_q <= {quo_q[QUO_W-2:0], trial_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      ST_SIGN: begin
        raw_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
      end
      ST_MIX1: begin
        prod_q <= raw_q * $signed({1'b0, w_new});
      end
      ST_MIX2: begin
        sum_q <= prod_q + filt_q * $signed({1'b0, w_old});
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign speed_rpm_o = speed_q;

endmodule

`default_nettype wire

/* bench/qre_speed_checker.sv */
`timescale 1ns / 1ps

module qre_speed_checker #(
  parameter int FRACTION_BITS = 8,
  parameter int COUNT_BITS    = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [qre_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  wire logic [qre_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                               in_valid_i,
  input  wire logic                               in_stall_i,
  input  wire logic [qre_pkg::CMD_W-1:0]          cmd_i,
  input  wire logic                               encoder_dir_i,
  input  wire logic                               out_valid_i,
  input  wire logic                               out_stall_i,
  input  wire logic signed [qre_pkg::SPEED_W-1:0] speed_rpm_i,
  output int                                      fail_count_o,
  output int                                      pending_o
);

  logic [qre_pkg::CPR_W-1:0]          counts_per_rev;
  logic [qre_pkg::ALPHA_W-1:0]        alpha_q8;
  logic [COUNT_BITS-1:0]              position;
  logic [COUNT_BITS-1:0]              snapshot;
  logic [qre_pkg::TIME_W-1:0]         elapsed_us;
  longint                             avg_speed_q;
  logic signed [qre_pkg::SPEED_W-1:0] speed_expected[$];
  int                                 mismatches;

  // Unfiltered speed in rpm with FRACTION_BITS fraction bits, symmetric in sign.
  function automatic longint raw_speed_q(input longint delta, input longint unsigned den);
    logic                 neg;
    longint unsigned      mag;
    longint unsigned      num;
    longint unsigned      quo;
    longint unsigned      rem;
    longint unsigned      v;
    neg = (delta < 0);
    mag = neg ? -delta : delta;
    num = mag * qre_pkg::US_PER_MIN;
    quo = num / den;
    rem = num % den;
    if (quo >= (64'd1 << (31 - FRACTION_BITS))) begin
      v = 64'h7FFF_FFFF;
    end else begin
      v = (quo << FRACTION_BITS) + ((rem << FRACTION_BITS) / den);
      if (v > 64'h7FFF_FFFF) begin
        v = 64'h7FFF_FFFF;
      end
    end
    return neg ? -longint'(v) : longint'(v);
  endfunction

  function automatic logic signed [qre_pkg::SPEED_W-1:0] take_sample();
    logic [COUNT_BITS-1:0] diff;
    longint                delta;
    longint unsigned       den;
    longint                weight;
    longint                whole;
    diff  = position - snapshot;
    delta = longint'($signed(diff));
    den   = 64'(counts_per_rev) * 64'(elapsed_us);
    if (den != 0) begin
      weight = (alpha_q8 > qre_pkg::ALPHA_ONE) ? longint'(qre_pkg::ALPHA_ONE)
                                               : longint'(alpha_q8);
      avg_speed_q = (raw_speed_q(delta, den) * weight
                     + avg_speed_q * (longint'(qre_pkg::ALPHA_ONE) - weight))
                    / longint'(qre_pkg::ALPHA_ONE);
    end
    snapshot   = position;
    elapsed_us = '0;
    whole = avg_speed_q / (longint'(1) <<< FRACTION_BITS);
    if (whole > qre_pkg::SPEED_MAX) begin
      whole = qre_pkg::SPEED_MAX;
    end
    if (whole < qre_pkg::SPEED_MIN) begin
      whole = qre_pkg::SPEED_MIN;
    end
    return whole[qre_pkg::SPEED_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [qre_pkg::SPEED_W-1:0] want;
    if (!rst_ni) begin
      counts_per_rev = qre_pkg::CPR_RESET;
      alpha_q8       = qre_pkg::ALPHA_RESET;
      position       = '0;
      snapshot       = '0;
      elapsed_us     = '0;
      avg_speed_q    = 0;
      speed_expected.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (speed_expected.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected speed item %0d", $realtime, speed_rpm_i);
          end
          mismatches++;
        end else begin
          want = speed_expected.pop_front();
          if (speed_rpm_i !== want) begin
            if (mismatches < 10) begin
              $display("%0t: speed_rpm expected %0d, got %0d", $realtime, want,
                       speed_rpm_i);
            end
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          qre_pkg::CFG_COUNTS_PER_REV: counts_per_rev = cfg_wdata_i[qre_pkg::CPR_W-1:0];
          qre_pkg::CFG_ALPHA_Q8:       alpha_q8 = cfg_wdata_i[qre_pkg::ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (cmd_i)
          qre_pkg::CMD_EDGE: begin
            if (encoder_dir_i) begin
              position = position + 1'b1;
            end else begin
              position = position - 1'b1;
            end
          end
          qre_pkg::CMD_TICK: begin
            if (elapsed_us != '1) begin
              elapsed_us = elapsed_us + 1'b1;
            end
          end
          qre_pkg::CMD_SAMPLE: speed_expected.push_back(take_sample());
          default: ;
        endcase
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= speed_expected.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int FRACTION_BITS = 8;
  localparam int COUNT_BITS    = 32;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam logic [qre_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [qre_pkg::CFG_ADDR_W-1:0]     cfg_addr = qre_pkg::CFG_COUNTS_PER_REV;
  logic [qre_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [qre_pkg::CMD_W-1:0]          cmd = qre_pkg::CMD_EDGE;
  logic                               encoder_dir = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [qre_pkg::SPEED_W-1:0] speed_rpm;
  int                                 fail_count;
  int                                 pending;

  int idle_mode = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int items_sent = 0;
  int samples_sent = 0;

  quadrature_rpm_estimator_core #(
    .FRACTION_BITS(FRACTION_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .encoder_dir_i(encoder_dir),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .speed_rpm_o  (speed_rpm)
  );

  qre_speed_checker #(
    .FRACTION_BITS(FRACTION_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) speed_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cmd_i        (cmd),
    .encoder_dir_i(encoder_dir),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .speed_rpm_i  (speed_rpm),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Random output stalls; on request, a long hold-off fills the block while the sender keeps offering items.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < ((idle_mode == 0) ? 70 : (idle_mode == 1) ? 17 : 0));
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic put_item(input logic [qre_pkg::CMD_W-1:0] c, input logic d);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 17 : (idle_mode == 1) ? 70 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    encoder_dir <= d;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (c != CMD_UNUSED) begin
      items_sent++;
    end
    if (c == qre_pkg::CMD_SAMPLE) begin
      samples_sent++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] cpr, input logic [15:0] alpha_word);
    cfg_we    <= 1'b1;
    cfg_addr  <= qre_pkg::CFG_COUNTS_PER_REV;
    cfg_wdata <= cpr;
    @(posedge clk);
    cfg_addr  <= qre_pkg::CFG_ALPHA_Q8;
    cfg_wdata <= alpha_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly a run of edges and ticks followed by a sample; sometimes plain noise.
  task automatic run_sequence();
    int   ticks;
    int   edges;
    logic main_dir;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(6, 1)) begin
        put_item(2'($urandom), 1'($urandom));
      end
    end else begin
      ticks    = ($urandom_range(29) == 0) ? $urandom_range(200, 100) : $urandom_range(12);
      edges    = $urandom_range(8);
      main_dir = 1'($urandom);
      while (ticks + edges > 0) begin
        if ($urandom_range(99) < 3) begin
          put_item(CMD_UNUSED, 1'($urandom));
        end else if ($urandom_range(ticks + edges - 1) < ticks) begin
          put_item(qre_pkg::CMD_TICK, 1'($urandom));
          ticks--;
        end else begin
          put_item(qre_pkg::CMD_EDGE,
                   ($urandom_range(99) < 85) ? main_dir : !main_dir);
          edges--;
        end
      end
      put_item(qre_pkg::CMD_SAMPLE, 1'($urandom));
    end
  endtask

  initial begin : stimulus
    int first_item;
    int first_sample;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_item(qre_pkg::CMD_SAMPLE, 1'b0);
    put_item(CMD_UNUSED, 1'b1);
    put_item(qre_pkg::CMD_EDGE, 1'b1);
    put_item(qre_pkg::CMD_EDGE, 1'b1);
    put_item(qre_pkg::CMD_EDGE, 1'b0);
    put_item(qre_pkg::CMD_TICK, 1'b0);
    put_item(qre_pkg::CMD_TICK, 1'b1);
    put_item(qre_pkg::CMD_SAMPLE, 1'b1);
    repeat (3) put_item(qre_pkg::CMD_EDGE, 1'b0);
    put_item(qre_pkg::CMD_TICK, 1'b0);
    put_item(qre_pkg::CMD_SAMPLE, 1'b0);
    put_item(qre_pkg::CMD_EDGE, 1'b1);
    put_item(qre_pkg::CMD_EDGE, 1'b1);
    put_item(CMD_UNUSED, 1'b0);
    put_item(qre_pkg::CMD_SAMPLE, 1'b0);
    put_item(qre_pkg::CMD_TICK, 1'b1);
    put_item(qre_pkg::CMD_SAMPLE, 1'b1);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: set_config(16'd1, 16'd256);
        1: set_config(16'hFFFF, 16'd1);
        2: set_config(16'd0, {7'($urandom), 9'h1FF});
        3: set_config(16'($urandom_range(65535, 1)), {7'($urandom), 9'd0});
        4: set_config(16'($urandom_range(2000, 100)), 16'($urandom_range(256, 1)));
        default: set_config(16'($urandom), 16'($urandom));
      endcase
      idle_mode = p / 2;
      if (p == 4) begin
        hold_requests <= hold_requests + 1;
      end
      first_item   = items_sent;
      first_sample = samples_sent;
      while (items_sent - first_item < 60 || samples_sent - first_sample < 4) begin
        run_sequence();
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
